>>> rtl/gsvc_pkg.sv
`default_nettype none
package gsvc_pkg;

  localparam int unsigned HEAD_W   = 15;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIN_W    = 19;
  localparam int unsigned ANG_OW   = 16;
  localparam int unsigned ANG_W    = 22;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned PI_Q16      = 205887;
  localparam int unsigned HALF_PI_Q16 = 102944;
  localparam int unsigned KINV_Q16    = 39797;
  localparam int unsigned LIN_MAX     = 524287;
  localparam int unsigned LIN_GAIN_RST = 3277;
  localparam int unsigned ANG_GAIN_RST = 8192;

  typedef enum logic [1:0] {
    REQ_GOAL = 2'd0,
    REQ_POSE = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic {
    REG_LIN_GAIN = 1'b0,
    REG_ANG_GAIN = 1'b1
  } reg_e;

  typedef struct packed {
    logic             store_goal;
    logic             store_pose;
    logic             init;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic             mul1;
    logic             mul2;
    logic             load_out;
  } cmd_t;

  function automatic logic [15:0] atan_q16(input logic [IDX_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gsvc_if.sv
`default_nettype none
interface gsvc_in_if #(parameter int unsigned COORD_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic signed [COORD_WIDTH-1:0]  pos_x;
  logic signed [COORD_WIDTH-1:0]  pos_y;
  logic signed [gsvc_pkg::HEAD_W-1:0] heading;
  modport source (output valid, req_type, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, heading, output ready);
endinterface

interface gsvc_out_if;
  logic                               valid;
  logic                               ready;
  logic [gsvc_pkg::LIN_W-1:0]         linear_velocity;
  logic signed [gsvc_pkg::ANG_OW-1:0] angular_velocity;
  modport source (output valid, linear_velocity, angular_velocity, input ready);
  modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface
`default_nettype wire

>>> rtl/gsvc_ctrl.sv
`default_nettype none
module gsvc_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  req_type_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output gsvc_pkg::cmd_t   cmd_o
);

  localparam int unsigned N  = (CORDIC_STEPS < gsvc_pkg::TABLE_LEN) ?
                               CORDIC_STEPS : gsvc_pkg::TABLE_LEN;
  localparam int unsigned CW = (N > 1) ? $clog2(N) : 1;
  localparam logic [CW-1:0] LAST = CW'(N - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_ITER, ST_MUL1, ST_MUL2, ST_FIN} state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          armed_q, armed_d;
  logic          out_valid_q, out_valid_d;
  logic          acc;
  gsvc_pkg::req_e req;

  assign req         = gsvc_pkg::req_e'(req_type_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    armed_d     = armed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = gsvc_pkg::IDX_W'(cnt_q);
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (req)
            gsvc_pkg::REQ_GOAL: begin
              cmd_o.store_goal = 1'b1;
              armed_d          = 1'b1;
            end
            gsvc_pkg::REQ_POSE: cmd_o.store_pose = 1'b1;
            gsvc_pkg::REQ_TICK: begin
              if (armed_q) begin
                cmd_o.init = 1'b1;
                cnt_d      = '0;
                state_d    = ST_ITER;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_init_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init |-> armed_q) else $error("tick started while unarmed");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && cnt_q == LAST) |=> state_q == ST_MUL1)
    else $error("iteration count overrun");
  a_goal_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store_goal |=> armed_q) else $error("goal did not arm");

endmodule
`default_nettype wire

>>> rtl/gsvc_datapath.sv
`default_nettype none
module gsvc_datapath #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire gsvc_pkg::cmd_t                       cmd_i,
  input  wire logic signed [COORD_WIDTH-1:0]        pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]        pos_y_i,
  input  wire logic signed [gsvc_pkg::HEAD_W-1:0]   heading_i,
  input  wire logic [gsvc_pkg::GAIN_W-1:0]          lin_gain_i,
  input  wire logic [gsvc_pkg::GAIN_W-1:0]          ang_gain_i,
  output logic [gsvc_pkg::LIN_W-1:0]                linear_velocity_o,
  output logic signed [gsvc_pkg::ANG_OW-1:0]        angular_velocity_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 12;
  localparam int unsigned PW = DW + 17;
  localparam int unsigned AW = gsvc_pkg::ANG_W;
  localparam int unsigned QW = AW + 17;
  localparam logic signed [AW-1:0] PI_A   = AW'(gsvc_pkg::PI_Q16);
  localparam logic signed [AW-1:0] HALF_A = AW'(gsvc_pkg::HALF_PI_Q16);
  localparam logic signed [QW-1:0] ANG_HI = QW'(32767);
  localparam logic signed [QW-1:0] ANG_LO = -QW'(32768);
  localparam logic signed [PW-1:0] LIN_HI = PW'(gsvc_pkg::LIN_MAX);

  logic signed [W-1:0] goal_x_q, goal_y_q, cur_x_q, cur_y_q;
  logic signed [gsvc_pkg::HEAD_W-1:0] cur_h_q;

  logic signed [DW-1:0] rx_q, ry_q, vx_q, vy_q;
  logic signed [AW-1:0] rz_q, vz_q, h16_q;
  logic                 zero_q;
  logic signed [DW-1:0] px_q;
  logic signed [QW-1:0] angp_q;
  logic signed [PW-1:0] linp_q;
  logic signed [gsvc_pkg::ANG_OW-1:0] ang_q;

  logic signed [DW-1:0] dx, dy, ex0, ey0;
  logic signed [AW-1:0] h16, zneg, atn;
  logic signed [DW-1:0] rx_n, ry_n, vx_n, vy_n;
  logic signed [AW-1:0] rz_n, vz_n, err;
  logic signed [PW-1:0] kprod, lprod, lsh;
  logic signed [QW-1:0] aprod, ash;

  always_comb begin
    dx  = DW'(goal_x_q) - DW'(cur_x_q);
    dy  = DW'(goal_y_q) - DW'(cur_y_q);
    ex0 = dx <<< 8;
    ey0 = dy <<< 8;
    h16 = AW'(cur_h_q) <<< 4;
    zneg = -h16;
    atn = AW'(gsvc_pkg::atan_q16(cmd_i.idx));
    if (rz_q >= 0) begin
      rx_n = rx_q - (ry_q >>> cmd_i.idx);
      ry_n = ry_q + (rx_q >>> cmd_i.idx);
      rz_n = rz_q - atn;
    end else begin
      rx_n = rx_q + (ry_q >>> cmd_i.idx);
      ry_n = ry_q - (rx_q >>> cmd_i.idx);
      rz_n = rz_q + atn;
    end
    if (vy_q < 0) begin
      vx_n = vx_q - (vy_q >>> cmd_i.idx);
      vy_n = vy_q + (vx_q >>> cmd_i.idx);
      vz_n = vz_q - atn;
    end else begin
      vx_n = vx_q + (vy_q >>> cmd_i.idx);
      vy_n = vy_q - (vx_q >>> cmd_i.idx);
      vz_n = vz_q + atn;
    end
    err   = (zero_q ? AW'(0) : vz_q) - h16_q;
    kprod = PW'(rx_q) * PW'($signed({1'b0, 16'(gsvc_pkg::KINV_Q16)}));
    aprod = QW'(err) * QW'($signed({1'b0, ang_gain_i}));
    lprod = PW'(px_q) * PW'($signed({1'b0, lin_gain_i}));
    lsh   = linp_q >>> 22;
    ash   = angp_q >>> 18;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      cur_h_q  <= '0;
    end else begin
      if (cmd_i.store_goal) begin
        goal_x_q <= pos_x_i;
        goal_y_q <= pos_y_i;
      end
      if (cmd_i.store_pose) begin
        cur_x_q <= pos_x_i;
        cur_y_q <= pos_y_i;
        cur_h_q <= heading_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      h16_q  <= h16;
      zero_q <= (ex0 == '0) && (ey0 == '0);
      if (zneg > HALF_A) begin
        rz_q <= zneg - PI_A;
        rx_q <= -ex0;
        ry_q <= -ey0;
      end else if (zneg < -HALF_A) begin
        rz_q <= zneg + PI_A;
        rx_q <= -ex0;
        ry_q <= -ey0;
      end else begin
        rz_q <= zneg;
        rx_q <= ex0;
        ry_q <= ey0;
      end
      if (ex0 < 0) begin
        vz_q <= (ey0 >= 0) ? PI_A : -PI_A;
        vx_q <= -ex0;
        vy_q <= -ey0;
      end else begin
        vz_q <= '0;
        vx_q <= ex0;
        vy_q <= ey0;
      end
    end else if (cmd_i.step) begin
      rx_q <= rx_n;
      ry_q <= ry_n;
      rz_q <= rz_n;
      vx_q <= vx_n;
      vy_q <= vy_n;
      vz_q <= vz_n;
    end
    if (cmd_i.mul1) begin
      px_q   <= kprod[DW+15:16];
      angp_q <= aprod;
    end
    if (cmd_i.mul2) begin
      linp_q <= lprod;
      if (ash > ANG_HI)      ang_q <= 16'sh7fff;
      else if (ash < ANG_LO) ang_q <= -16'sh8000;
      else                   ang_q <= ash[gsvc_pkg::ANG_OW-1:0];
    end
    if (cmd_i.load_out) begin
      angular_velocity_o <= ang_q;
      if (lsh < 0)           linear_velocity_o <= '0;
      else if (lsh > LIN_HI) linear_velocity_o <= gsvc_pkg::LIN_W'(gsvc_pkg::LIN_MAX);
      else                   linear_velocity_o <= lsh[gsvc_pkg::LIN_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/goal_seek_velocity_controller.sv
`default_nettype none
// Channel  Dir  Transfer when        Payload
// in_i     in   valid && ready       req_type, pos_x, pos_y, heading
// out_o    out  valid && ready       linear_velocity, angular_velocity
// apb      in   psel&penable&pwrite  linear_gain @0x0, angular_gain @0x4
//
// An armed tick runs min(CORDIC_STEPS,24) CORDIC steps, one per cycle, each
// advancing both the projection and the atan2 rotators on a shared step index,
// then two multiply stages and a result load.
// Reset clears the gains to defaults, pose and goal to zero, and disarms.
// A result waiting on out_o holds the next tick in its final cycle only.
module goal_seek_velocity_controller #(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gsvc_in_if.sink          in_i,
  gsvc_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [gsvc_pkg::GAIN_W-1:0] lin_gain_q, ang_gain_q;
  gsvc_pkg::cmd_t cmd;
  gsvc_pkg::reg_e sel;

  assign pready = 1'b1;
  assign sel    = gsvc_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= gsvc_pkg::GAIN_W'(gsvc_pkg::LIN_GAIN_RST);
      ang_gain_q <= gsvc_pkg::GAIN_W'(gsvc_pkg::ANG_GAIN_RST);
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        gsvc_pkg::REG_LIN_GAIN: lin_gain_q <= pwdata[gsvc_pkg::GAIN_W-1:0];
        gsvc_pkg::REG_ANG_GAIN: ang_gain_q <= pwdata[gsvc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      gsvc_pkg::REG_LIN_GAIN: prdata = 32'(lin_gain_q);
      gsvc_pkg::REG_ANG_GAIN: prdata = 32'(ang_gain_q);
      default: prdata = '0;
    endcase
  end

  gsvc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .req_type_i  (in_i.req_type),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  gsvc_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .pos_x_i            (in_i.pos_x),
    .pos_y_i            (in_i.pos_y),
    .heading_i          (in_i.heading),
    .lin_gain_i         (lin_gain_q),
    .ang_gain_i         (ang_gain_q),
    .linear_velocity_o  (out_o.linear_velocity),
    .angular_velocity_o (out_o.angular_velocity)
  );

endmodule
`default_nettype wire

>>> tb/tb_goal_seek_velocity_controller.sv
module tb_goal_seek_velocity_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LIMIT = 20000;

  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  x;
    logic [15:0]  y;
    logic [14:0]  hd;
  } cmd_item_t;

  typedef struct packed {
    logic [18:0] lin;
    logic [15:0] ang;
  } vel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gsvc_in_if #(.COORD_WIDTH(16)) cmd_ch ();
  gsvc_out_if vel_ch ();

  goal_seek_velocity_controller #(.COORD_WIDTH(16), .CORDIC_STEPS(STEPS)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch.sink), .out_o(vel_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cmd_item_t pending_cmds[$];
  vel_t      expected_vels[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  bit        in_took = 1'b0;

  longint lin_gain, ang_gain;
  longint gx, gy, cx, cy, ch;
  bit     armed;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint t [0:23] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    return t[i];
  endfunction

  function automatic longint heading_proj(longint x, longint y, longint h);
    longint z, nx;
    z = -h;
    if (z > longint'(gsvc_pkg::HALF_PI_Q16)) begin
      z -= longint'(gsvc_pkg::PI_Q16); x = -x; y = -y;
    end else if (z < -longint'(gsvc_pkg::HALF_PI_Q16)) begin
      z += longint'(gsvc_pkg::PI_Q16); x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_step(i);
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_step(i);
      end
      x = nx;
    end
    return floor_shr(x * longint'(gsvc_pkg::KINV_Q16), 16);
  endfunction

  function automatic longint bearing(longint x, longint y);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(gsvc_pkg::PI_Q16) : -longint'(gsvc_pkg::PI_Q16);
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y < 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_step(i);
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic predict_velocity(cmd_item_t c);
    longint ex, ey, h, lin, ang;
    vel_t v;
    case (gsvc_pkg::req_e'(c.kind))
      gsvc_pkg::REQ_GOAL: begin
        gx = longint'($signed(c.x)); gy = longint'($signed(c.y)); armed = 1'b1;
      end
      gsvc_pkg::REQ_POSE: begin
        cx = longint'($signed(c.x)); cy = longint'($signed(c.y));
        ch = longint'($signed(c.hd));
      end
      gsvc_pkg::REQ_TICK: if (armed) begin
        ex = (gx - cx) * 256;
        ey = (gy - cy) * 256;
        h = ch * 16;
        lin = floor_shr(heading_proj(ex, ey, h) * lin_gain, 22);
        if (lin < 0) lin = 0;
        if (lin > longint'(gsvc_pkg::LIN_MAX)) lin = longint'(gsvc_pkg::LIN_MAX);
        ang = floor_shr((bearing(ex, ey) - h) * ang_gain, 18);
        if (ang > 32767) ang = 32767;
        if (ang < -32768) ang = -32768;
        v.lin = lin[18:0];
        v.ang = ang[15:0];
        expected_vels.push_back(v);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    in_took <= cmd_ch.valid && cmd_ch.ready;
  end

  // sender
  int send_gap = 0;
  initial begin
    cmd_ch.valid = 1'b0; cmd_ch.req_type = '0;
    cmd_ch.pos_x = '0; cmd_ch.pos_y = '0; cmd_ch.heading = '0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_ch.valid && !in_took) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 6);
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.valid    <= 1'b1;
          cmd_ch.req_type <= pending_cmds[0].kind;
          cmd_ch.pos_x    <= pending_cmds[0].x;
          cmd_ch.pos_y    <= pending_cmds[0].y;
          cmd_ch.heading  <= pending_cmds[0].hd;
          void'(pending_cmds.pop_front());
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  int recv_gap = 0;
  initial vel_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        vel_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        vel_ch.ready <= 1'b0;
      end else begin
        vel_ch.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vel_t got, want;
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (vel_ch.valid && vel_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_velocity(cmd_item_t'{cmd_ch.req_type, cmd_ch.pos_x, cmd_ch.pos_y,
                                     cmd_ch.heading});
      end
      if (vel_ch.valid && vel_ch.ready) begin
        got.lin = vel_ch.linear_velocity;
        got.ang = vel_ch.angular_velocity;
        if (expected_vels.size() == 0) begin
          $display("%0t: unexpected velocity transfer lin=%0d ang=%0d", $time,
                   got.lin, $signed(got.ang));
          fail_count++;
        end else begin
          want = expected_vels.pop_front();
          if (got.lin !== want.lin) begin
            $display("%0t: linear_velocity exp=%0d got=%0d", $time, want.lin, got.lin);
            fail_count++;
          end
          if (got.ang !== want.ang) begin
            $display("%0t: angular_velocity exp=%0d got=%0d", $time,
                     $signed(want.ang), $signed(got.ang));
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic cmd_item_t mk(gsvc_pkg::req_e k, int x, int y, int hd);
    cmd_item_t c;
    c.kind = k; c.x = x[15:0]; c.y = y[15:0]; c.hd = hd[14:0];
    return c;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return ($urandom_range(0, 1) ? 32767 : -32768);
      2: return 0;
      default: return $urandom_range(0, 16383) - 8192;
    endcase
  endfunction

  function automatic int pick_heading();
    case ($urandom_range(0, 4))
      0: return ($urandom_range(0, 1) ? 12868 : -12868);
      1: return 0;
      2: return $urandom_range(0, 32767) - 16384;
      default: return $urandom_range(0, 25736) - 12868;
    endcase
  endfunction

  task automatic apb_write(gsvc_pkg::reg_e r, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(int'(r) * 4); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (r == gsvc_pkg::REG_LIN_GAIN) lin_gain = val & 16'hFFFF;
    else ang_gain = val & 16'hFFFF;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0);
    @(posedge clk_i);
    while (cmd_ch.valid || expected_vels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int unsigned gain_set [0:4][0:1] = '{'{3277, 8192}, '{0, 0}, '{65535, 65535},
                                         '{16384, 1}, '{1, 16384}};
    lin_gain = gsvc_pkg::LIN_GAIN_RST; ang_gain = gsvc_pkg::ANG_GAIN_RST;
    gx = 0; gy = 0; cx = 0; cy = 0; ch = 0; armed = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_NONE, 100, 100, 100));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, 32767, 32767, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, -32768, -32768, 12868));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, -32768, 32767, -12868));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, -32768, -32768, 16383));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, 32767, 32767, -16384));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, 32767, -32768, 12868));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, -4096, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, -4096, -1, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, 0, 4096, 0));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, 0, 0, 6434));
    pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      apb_write(gsvc_pkg::REG_LIN_GAIN, gain_set[ph][0]);
      apb_write(gsvc_pkg::REG_ANG_GAIN, gain_set[ph][1]);
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < 300; n++) begin
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
          pending_cmds.push_back(mk(gsvc_pkg::REQ_GOAL, pick_coord(), pick_coord(), 0));
        else if (sel < 5)
          pending_cmds.push_back(mk(gsvc_pkg::REQ_POSE, pick_coord(), pick_coord(),
                                    pick_heading()));
        else if (sel < 9)
          pending_cmds.push_back(mk(gsvc_pkg::REQ_TICK, pick_coord(), pick_coord(),
                                    pick_heading()));
        else
          pending_cmds.push_back(mk(gsvc_pkg::REQ_NONE, pick_coord(), pick_coord(),
                                    pick_heading()));
        if (ph == 2 && n == 150) begin
          drain();
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gsvc_pkg.sv
rtl/gsvc_if.sv
rtl/gsvc_ctrl.sv
rtl/gsvc_datapath.sv
rtl/goal_seek_velocity_controller.sv
tb/tb_goal_seek_velocity_controller.sv
